[design/assert_macros.svh]
// Assertion helpers for the top-level design file.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge.
`define EFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle in which the antecedent holds.
`define EFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `EFR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[design/efr_pkg.sv]
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int MAX_FRAME_BYTES = 512;
  // The byte counter must hold MAX_FRAME_BYTES itself.
  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W  = 9;
  localparam int WIDE_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] START_RST       = 8'd193;
  localparam logic [7:0] END_RST         = 8'd192;
  localparam logic [7:0] ESC_RST         = 8'd219;
  localparam logic [7:0] ESC_END_RST     = 8'd220;
  localparam logic [7:0] ESC_ESC_RST     = 8'd221;
  localparam logic [7:0] ESC_START_RST   = 8'd222;

  typedef enum logic [2:0] {
    REG_START_CODE     = 3'd0,
    REG_END_CODE       = 3'd1,
    REG_ESCAPE_CODE    = 3'd2,
    REG_ESC_END_CODE   = 3'd3,
    REG_ESC_ESC_CODE   = 3'd4,
    REG_ESC_START_CODE = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic       is_escape;
    logic       is_start;
    logic       is_end;
    logic [7:0] raw_byte;   // byte as received
    logic [7:0] esc_byte;   // byte as it reads after an escape
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic [7:0]       frame_type;
    logic [IDX_W-1:0] frame_length;
  } result_t;

endpackage

[design/efr_front.sv]
// ----------------------------------------------------------------------------
// efr_front
// Holds the framing codes and classifies each received byte against them.
// ----------------------------------------------------------------------------
module efr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        rx_byte,
  output efr_pkg::q_entry_t entry
);
  import efr_pkg::*;

  logic [7:0] start_r, end_r, esc_r, esc_end_r, esc_esc_r, esc_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_RST;
      end_r       <= END_RST;
      esc_r       <= ESC_RST;
      esc_end_r   <= ESC_END_RST;
      esc_esc_r   <= ESC_ESC_RST;
      esc_start_r <= ESC_START_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_START_CODE:     start_r     <= cfg_data;
        REG_END_CODE:       end_r       <= cfg_data;
        REG_ESCAPE_CODE:    esc_r       <= cfg_data;
        REG_ESC_END_CODE:   esc_end_r   <= cfg_data;
        REG_ESC_ESC_CODE:   esc_esc_r   <= cfg_data;
        REG_ESC_START_CODE: esc_start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    entry.is_escape = (rx_byte == esc_r);
    entry.is_start  = (rx_byte == start_r);
    entry.is_end    = (rx_byte == end_r);
    entry.raw_byte  = rx_byte;
    // Translation order: escape, then end, then start.
    if (rx_byte == esc_esc_r)
      entry.esc_byte = esc_r;
    else if (rx_byte == esc_end_r)
      entry.esc_byte = end_r;
    else if (rx_byte == esc_start_r)
      entry.esc_byte = start_r;
    else
      entry.esc_byte = rx_byte;
  end

endmodule

[design/efr_queue.sv]
// ----------------------------------------------------------------------------
// efr_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module efr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  efr_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output efr_pkg::q_entry_t  head,
  output efr_pkg::q_status_t status
);
  import efr_pkg::*;

  q_entry_t          mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)
      count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push)
      count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_entry;
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.full  = (count_r == QCNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

[design/efr_back.sv]
// ----------------------------------------------------------------------------
// efr_back
// Frame state machine: unstuffing, checksum, counting and result register.
// ----------------------------------------------------------------------------
module efr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  efr_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output efr_pkg::result_t  res
);
  import efr_pkg::*;

  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic             type_seen_r, type_seen_nxt;
  logic [7:0]       type_r, type_nxt;
  logic             drain_r, drain_nxt;
  logic             valid_r;
  result_t          res_r;

  logic             emit;
  result_t          emit_res;
  logic [7:0]       c;
  logic [WIDE_W-1:0] idx_wide, len_wide;

  assign q_pop    = q_valid && (!valid_r || res_ready);
  assign c        = esc_pend_r ? q_head.esc_byte : q_head.raw_byte;
  assign idx_wide = WIDE_W'(cnt_r);
  assign len_wide = WIDE_W'(cnt_r - CNT_W'(1));

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    esc_pend_nxt  = esc_pend_r;
    type_seen_nxt = type_seen_r;
    type_nxt      = type_r;
    drain_nxt     = drain_r;
    emit          = 1'b0;
    emit_res      = '{kind: KIND_PAYLOAD, default: '0};

    if (drain_r) begin
      // Ignore everything up to the end byte.
      if (q_head.is_end) begin
        emit          = 1'b1;
        emit_res.kind = KIND_OVERFLOW;
      end
    end else if (q_head.is_escape) begin
      esc_pend_nxt = 1'b1;
    end else if (q_head.is_start) begin
      // clear below
    end else if (q_head.is_end) begin
      if (type_seen_r && cnt_r != '0) begin
        emit = 1'b1;
        if (sum_r == 8'd0) begin
          emit_res.kind         = KIND_GOOD;
          emit_res.frame_type   = type_r;
          emit_res.frame_length = len_wide[IDX_W-1:0];
        end else begin
          emit_res.kind = KIND_CSUM_ERR;
        end
      end
    end else begin
      sum_nxt      = sum_r + c;
      esc_pend_nxt = 1'b0;
      if (!type_seen_r) begin
        type_seen_nxt = 1'b1;
        type_nxt      = c;
      end else if (cnt_r >= CNT_W'(MAX_FRAME_BYTES)) begin
        drain_nxt = 1'b1;
      end else begin
        cnt_nxt             = cnt_r + CNT_W'(1);
        emit                = 1'b1;
        emit_res.byte_index = idx_wide[IDX_W-1:0];
        emit_res.byte_value = c;
      end
    end

    // Non-escape start or end bytes clear the frame; while draining, only end.
    if ((!drain_r && !q_head.is_escape && q_head.is_start) ||
        (q_head.is_end && (drain_r || !q_head.is_escape && !q_head.is_start))) begin
      sum_nxt       = '0;
      cnt_nxt       = '0;
      esc_pend_nxt  = 1'b0;
      type_seen_nxt = 1'b0;
      type_nxt      = '0;
      drain_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      esc_pend_r  <= 1'b0;
      type_seen_r <= 1'b0;
      type_r      <= '0;
      drain_r     <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      if (q_pop) begin
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
        esc_pend_r  <= esc_pend_nxt;
        type_seen_r <= type_seen_nxt;
        type_r      <= type_nxt;
        drain_r     <= drain_nxt;
      end
      if (q_pop && emit)
        valid_r <= 1'b1;
      else if (res_ready)
        valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit)
      res_r <= emit_res;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

[design/escaped_frame_receiver.sv]
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-stuffed frame receiver with an 8-bit checksum.
// ----------------------------------------------------------------------------
// Raw line bytes enter on the in_ stream, one per transaction in in_tdata.
// Framing codes are six 8-bit registers written on the cfg_ channel
// (cfg_index 0..5; other indexes are ignored); write them only while idle.
// Each byte produces zero or one result on the out_ stream: a payload byte
// with its index, or at the end byte a good frame, checksum error or
// overflow, with the kind in out_tuser.
// Throughput is one byte per cycle while out_tready is high. A byte passes a
// combinational code compare into a two-entry queue, then the frame state
// unit, whose result register drives out_; a result is valid on out_ once its
// byte has left the queue and been loaded into the result register. The sum
// and counter update in the back sets the rate. When out_tready is low the
// result holds, the queue fills and in_tready drops once both entries are
// taken. Reset clears the frame state and queue, empties the output and loads
// the default codes; it is synchronous and active low.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [8:0] byte_index, [16:9] byte_value,
                                  // [24:17] frame_type, [33:25] frame_length,
                                  // [39:34] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import efr_pkg::*;

  `include "assert_macros.svh"

  q_entry_t  push_entry, head;
  q_status_t q_stat;
  logic      push, pop;
  result_t   res;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  efr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (in_tdata),
    .entry     (push_entry)
  );

  efr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_stat)
  );

  efr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_head    (head),
    .q_pop     (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {6'd0, res.frame_length, res.frame_type, res.byte_value, res.byte_index};

  `EFR_ASSERT(a_q_bound, q_stat.count <= QCNT_W'(Q_DEPTH), "queue count past depth")
  `EFR_ASSERT_IMPLY(a_q_no_under, pop, !q_stat.empty, "pop from empty queue")
  `EFR_ASSERT_IMPLY(a_frame_fields,
                    out_tvalid && (out_tuser != KIND_PAYLOAD),
                    (out_tdata[16:0] == 17'd0), "frame report carries payload fields")
  `EFR_ASSERT_IMPLY(a_stall_fills, !out_tready && out_tvalid && !q_stat.empty,
                    !pop, "back advanced while result stalled")

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the escaped frame receiver.
// ----------------------------------------------------------------------------
// Raw line bytes go out from a queue through a clocked driver. Each accepted
// byte runs through a local model of the deframer, which queues the results it
// predicts. A clocked monitor checks every result transaction field by field.
// The run goes through several code settings, directed frames and a long
// frame past the size limit, then random well-formed, corrupt and broken
// frames, with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
module tb;
  import efr_pkg::*;

  localparam int          CYCLE_LIMIT      = 100000;
  localparam int          RANDOM_PER_PHASE = 20;
  localparam int          NUM_PHASES       = 5;
  localparam int          SETTLE_CYCLES    = 8;
  localparam logic [2:0]  REG_UNMAPPED_LO  = 3'd6;
  localparam logic [2:0]  REG_UNMAPPED_HI  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  escaped_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Deframer model state
  logic [7:0]  codes [6] = '{START_RST, END_RST, ESC_RST, ESC_END_RST, ESC_ESC_RST,
                             ESC_START_RST};
  logic [7:0]  frame_sum = '0;
  int unsigned frame_count = 0;
  bit          esc_pending = 1'b0;
  bit          type_seen = 1'b0;
  logic [7:0]  type_byte = '0;
  bit          draining = 1'b0;

  logic [7:0]  line_bytes [$];
  result_t     predicted_results [$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count = 0;
  bit          in_taken = 1'b0;
  bit          failed = 1'b0;
  result_t     oldest;

  function automatic void clear_frame();
    frame_sum   = '0;
    frame_count = 0;
    esc_pending = 1'b0;
    type_seen   = 1'b0;
    type_byte   = '0;
    draining    = 1'b0;
  endfunction

  // Advance the model by one line byte and queue the result it causes.
  function automatic void deframe_byte(input logic [7:0] rx);
    logic [7:0] c;
    result_t    r;
    c = rx;
    r = '0;
    if (draining) begin
      if (c == codes[REG_END_CODE]) begin
        clear_frame();
        r.kind = KIND_OVERFLOW;
        predicted_results.push_back(r);
      end
    end else if (c == codes[REG_ESCAPE_CODE]) begin
      esc_pending = 1'b1;
    end else if (c == codes[REG_START_CODE]) begin
      clear_frame();
    end else if (c == codes[REG_END_CODE]) begin
      // Drop empty and typeless frames without a result.
      if (type_seen && frame_count != 0) begin
        if (frame_sum == 8'd0) begin
          r.kind         = KIND_GOOD;
          r.frame_type   = type_byte;
          r.frame_length = IDX_W'(frame_count - 1);
        end else begin
          r.kind = KIND_CSUM_ERR;
        end
        predicted_results.push_back(r);
      end
      clear_frame();
    end else begin
      if (esc_pending) begin
        if (c == codes[REG_ESC_ESC_CODE])
          c = codes[REG_ESCAPE_CODE];
        else if (c == codes[REG_ESC_END_CODE])
          c = codes[REG_END_CODE];
        else if (c == codes[REG_ESC_START_CODE])
          c = codes[REG_START_CODE];
      end
      frame_sum   = frame_sum + c;
      esc_pending = 1'b0;
      if (!type_seen) begin
        type_seen = 1'b1;
        type_byte = c;
      end else begin
        frame_count++;
        if (frame_count > MAX_FRAME_BYTES) begin
          draining = 1'b1;
        end else begin
          r.kind       = KIND_PAYLOAD;
          r.byte_index = IDX_W'(frame_count - 1);
          r.byte_value = c;
          predicted_results.push_back(r);
        end
      end
    end
  endfunction

  function automatic void send_byte(input logic [7:0] b);
    line_bytes.push_back(b);
    n_queued++;
  endfunction

  // Stuff a data byte with the current codes.
  function automatic void send_stuffed(input logic [7:0] b);
    if (b == codes[REG_ESCAPE_CODE]) begin
      send_byte(codes[REG_ESCAPE_CODE]);
      send_byte(codes[REG_ESC_ESC_CODE]);
    end else if (b == codes[REG_START_CODE]) begin
      send_byte(codes[REG_ESCAPE_CODE]);
      send_byte(codes[REG_ESC_START_CODE]);
    end else if (b == codes[REG_END_CODE]) begin
      send_byte(codes[REG_ESCAPE_CODE]);
      send_byte(codes[REG_ESC_END_CODE]);
    end else begin
      send_byte(b);
    end
  endfunction

  // Queue start (skipped in about one frame in ten), type, payload and checksum; the caller closes the frame.
  function automatic void send_frame(input int n_payload, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    if ($urandom_range(9) != 0)
      send_byte(codes[REG_START_CODE]);
    b = 8'($urandom);
    sum = b;
    send_stuffed(b);
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_stuffed(b);
    end
    b = 8'd0 - sum;
    if (bad_sum)
      b = b + 8'($urandom_range(1, 255));
    send_stuffed(b);
  endfunction

  task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_ESC_START_CODE)
      codes[idx] = val;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Driver: predict on each accepted transaction, refill at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      deframe_byte(in_tdata);
      n_accepted++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (line_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= line_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        $error("result with none pending: kind %0d, tdata %h", out_tuser, out_tdata);
        failed = 1'b1;
      end else begin
        oldest = predicted_results.pop_front();
        check_field("kind", oldest.kind, out_tuser);
        check_field("byte_index", oldest.byte_index, out_tdata[8:0]);
        check_field("byte_value", oldest.byte_value, out_tdata[16:9]);
        check_field("frame_type", oldest.frame_type, out_tdata[24:17]);
        check_field("frame_length", oldest.frame_length, out_tdata[33:25]);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n)
      out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0]  directed_seq [26];
    logic [7:0]  sc, ec, xc, xe, xx, xs;
    reg_idx_t    ri;
    int unsigned target;
    int unsigned pick;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        // Hold config writes until the block is idle.
        while (n_accepted != n_queued || predicted_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        case (ph)
          1: begin
            ri = ri.first();
            repeat (6) begin
              write_code(ri, 8'($urandom));
              ri = ri.next();
            end
          end
          2: begin
            write_code(REG_START_CODE, 8'hFF);
            write_code(REG_END_CODE, 8'h00);
            write_code(REG_ESCAPE_CODE, 8'h01);
            write_code(REG_ESC_END_CODE, 8'hFE);
            write_code(REG_ESC_ESC_CODE, 8'h80);
            write_code(REG_ESC_START_CODE, 8'h7F);
          end
          3: begin
            // Colliding codes: escape shadows start, translations overlap.
            write_code(REG_START_CODE, 8'h00);
            write_code(REG_END_CODE, 8'hFF);
            write_code(REG_ESCAPE_CODE, 8'h00);
            write_code(REG_ESC_END_CODE, 8'h00);
            write_code(REG_ESC_ESC_CODE, 8'hFF);
            write_code(REG_ESC_START_CODE, 8'hFF);
          end
          default: begin
            ri = ri.first();
            repeat (6) begin
              write_code(ri, 8'($urandom));
              ri = ri.next();
            end
            write_code(REG_UNMAPPED_LO, 8'($urandom));
            write_code(REG_UNMAPPED_HI, 8'($urandom));
          end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
      end

      @(posedge clk);
      case (ph)
        1: begin in_idle_pct = 70; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 70; end
        3, 4: begin in_idle_pct = 10; out_stall_pct = 10; end
        default: begin in_idle_pct = 0; out_stall_pct = 0; end
      endcase

      if (ph == 0) begin
        sc = codes[REG_START_CODE];
        ec = codes[REG_END_CODE];
        xc = codes[REG_ESCAPE_CODE];
        xe = codes[REG_ESC_END_CODE];
        xx = codes[REG_ESC_ESC_CODE];
        xs = codes[REG_ESC_START_CODE];
        // Empty frame, frame with a type byte only, every translation, escape after escape,
        // bare translation code, then a start after escape and a bad checksum.
        directed_seq = '{ec, sc, 8'h05, ec,
                         sc, xc, xe, xc, xx, xc, xs, xc, xc, xx, xe, xc, 8'h7F, 8'h6E, ec,
                         8'h00, 8'h22, xc, sc, 8'h33, 8'hFF, ec};
        foreach (directed_seq[i])
          send_byte(directed_seq[i]);
        // Frame whose checksum byte overflows after the last indexed payload
        // byte; the drain must ignore raw start and escape bytes.
        send_frame(MAX_FRAME_BYTES, 1'b0);
        send_byte(sc);
        send_byte(xc);
        send_byte(8'h42);
        send_byte(ec);
      end

      target = n_queued + RANDOM_PER_PHASE;
      while (n_queued < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame($urandom_range(12), $urandom_range(99) < 15);
          if ($urandom_range(19) != 0)
            send_byte(codes[REG_END_CODE]);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(codes[$urandom_range(5)]);
        end
      end
    end

    while (n_accepted != n_queued || predicted_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (!failed)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/efr_pkg.sv
design/efr_front.sv
design/efr_queue.sv
design/efr_back.sv
design/escaped_frame_receiver.sv
tb/sv/tb.sv
